/* design/doei_pkg.sv */
// Shared types and constants for the duplicate observation error inflation block.
package doei_pkg;

  localparam int RAD_W = 44;
  localparam int ROOT_W = 22;
  localparam int FACTOR_W = 22;
  localparam int TIME_W = 34;
  localparam int CODE_W = 32;
  localparam int WIN_W = 20;
  localparam int CFG_DATA_W = 20;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [1:0] {
    CFG_USE_PRESSURE,
    CFG_RETENTION,
    CFG_WINDOW,
    CFG_ENTRIES
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SELF,
    ST_SCAN,
    ST_DIV,
    ST_SQUARE,
    ST_SCALE,
    ST_ACC,
    ST_FINISH,
    ST_ROOT
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] lat;
    logic [CODE_W-1:0] lon;
    logic [CODE_W-1:0] pres;
    logic [TIME_W-1:0] tim;
    logic              pass;
  } record_t;

endpackage

/* design/doei_sqrt.sv */
// Iterative integer square root, one result bit per cycle.
module doei_sqrt
  import doei_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(ROOT_W);
        rad    <= radicand;
        rem    <= '0;
        root   <= '0;
      end else if (active) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/duplicate_obs_error_inflation_core.sv */
// Duplicate observation error inflation: entry memory, scan sequencer and result logic.
//
// A load writes its entry and busy stays low. An evaluate reads its own entry and, if it
// passed QC, scans the first min(entries_in_use, ENTRY_COUNT) entries through the entry
// memory's single read port, one per cycle; each counted duplicate stalls the scan through
// the bit-serial time divider when the time difference lies inside the window, then the
// square, scale, accumulate and reissue steps. A factor above one that does not saturate
// then runs the iterative square root. The result appears on error_factor/duplicate_seen
// for exactly one cycle with result_valid; it cannot be held off. A new item may start in
// that same cycle.
module duplicate_obs_error_inflation_core
  import doei_pkg::*;
#(
  parameter int ENTRY_COUNT   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                operation,
  input  logic [9:0]          entry_index,
  input  logic [CODE_W-1:0]   latitude_word,
  input  logic [CODE_W-1:0]   longitude_word,
  input  logic [CODE_W-1:0]   pressure_word,
  input  logic [TIME_W-1:0]   time_seconds,
  input  logic [7:0]          qc_flag,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cfg_index_t          cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                result_valid,
  output logic [FACTOR_W-1:0] error_factor,
  output logic                duplicate_seen
);

  localparam int AW  = $clog2(ENTRY_COUNT);
  localparam int CW  = $clog2(ENTRY_COUNT + 1);
  localparam int F   = FRACTION_BITS;
  localparam int FW  = F + 1;
  localparam int TW  = F + CW + 1;
  localparam int DCW = $clog2(F + 1);
  localparam logic [FW-1:0] FIX_ONE = {1'b1, {F{1'b0}}};
  localparam logic [63:0] SAT_LIMIT = 64'd1 << (44 - FRACTION_BITS);
  localparam logic [FACTOR_W-1:0] FACTOR_ONE =
    (FRACTION_BITS > 21) ? FACTOR_MAX : FACTOR_W'(64'd1 << FRACTION_BITS);

  // configuration
  logic              use_pressure;
  logic [16:0]       retention_weight;
  logic [WIN_W-1:0]  window_seconds;
  logic [10:0]       entries_in_use;

  // memory
  record_t           mem [ENTRY_COUNT];
  record_t           rd_rec;
  record_t           wr_rec;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  state_t            state;
  state_t            state_next;
  record_t           self_rec;
  logic [AW-1:0]     self_idx;
  logic [CW-1:0]     scan_limit;
  logic [CW-1:0]     issue_idx;
  logic [CW-1:0]     chk_idx;
  logic              chk_valid;
  logic [WIN_W-1:0]  win_eff;
  logic [FW-1:0]     one_minus_w;
  logic [WIN_W-1:0]  div_rem;
  logic [DCW-1:0]    div_cnt;
  logic [FW-1:0]     t;
  logic [FW-1:0]     t2;
  logic [FW-1:0]     scaled;
  logic [TW-1:0]     total;
  logic              seen;

  logic              idx_ok;
  logic [AW-1:0]     addr_in;
  logic              accept;
  logic              match;
  logic              issue;
  logic              need_root;
  logic              big_total;
  logic [TIME_W-1:0] tdiff;
  logic [WIN_W:0]    div_sh;
  logic [2*FW-1:0]   sq_full;
  logic [2*FW-1:0]   sc_full;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [63:0]       rad_wide;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign idx_ok    = (32'(entry_index) < ENTRY_COUNT);
  assign addr_in   = AW'(entry_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      use_pressure     <= 1'b0;
      retention_weight <= 17'd32768;
      window_seconds   <= 20'd10800;
      entries_in_use   <= 11'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_USE_PRESSURE: use_pressure     <= cfg_data[0];
        CFG_RETENTION:    retention_weight <= {1'b0, cfg_data[15:0]} | {cfg_data[16], 16'd0};
        CFG_WINDOW:       window_seconds   <= cfg_data;
        CFG_ENTRIES:      entries_in_use   <= cfg_data[10:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    wr_rec.lat  = latitude_word;
    wr_rec.lon  = longitude_word;
    wr_rec.pres = pressure_word;
    wr_rec.tim  = time_seconds;
    wr_rec.pass = (qc_flag == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_in] <= wr_rec;
    if (mem_re) rd_rec <= mem[mem_raddr];
  end

  always_comb begin
    match = chk_valid && (chk_idx != CW'(self_idx)) && rd_rec.pass &&
            (rd_rec.lat == self_rec.lat) && (rd_rec.lon == self_rec.lon) &&
            (!use_pressure || (rd_rec.pres == self_rec.pres));
    tdiff = (self_rec.tim > rd_rec.tim) ? self_rec.tim - rd_rec.tim
                                        : rd_rec.tim - self_rec.tim;
    issue     = (issue_idx < scan_limit) && !match;
    big_total = (64'(total) >= SAT_LIMIT);
    need_root = (total > TW'(FIX_ONE)) && !big_total;
    div_sh    = {div_rem, 1'b0};
    sq_full   = t * t;
    sc_full   = t2 * one_minus_w;
    rad_wide  = 64'(total) << F;
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = issue_idx[AW-1:0];
    sqrt_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_LOAD) begin
            mem_we = idx_ok;
          end else if (idx_ok) begin
            mem_re     = 1'b1;
            mem_raddr  = addr_in;
            state_next = ST_SELF;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SELF: state_next = rd_rec.pass ? ST_SCAN : ST_FINISH;
      ST_SCAN: begin
        mem_re = issue;
        if (match) begin
          state_next = (tdiff >= TIME_W'(win_eff)) ? ST_SQUARE : ST_DIV;
        end else if (!chk_valid && !issue) begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV:    if (div_cnt == DCW'(1)) state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_ACC;
      ST_ACC:    state_next = ST_SCAN;
      ST_FINISH: begin
        if (need_root) begin
          sqrt_start = 1'b1;
          state_next = ST_ROOT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ROOT:   if (sqrt_done) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      chk_valid    <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && operation == OP_EVAL) begin
            self_idx   <= addr_in;
            scan_limit <= (32'(entries_in_use) > ENTRY_COUNT) ? CW'(ENTRY_COUNT)
                                                               : CW'(entries_in_use);
            win_eff    <= (window_seconds == '0) ? WIN_W'(1) : window_seconds;
            one_minus_w <= (32'(retention_weight) > 32'(FIX_ONE)) ? '0
                           : FIX_ONE - FW'(retention_weight);
            total      <= TW'(FIX_ONE);
            seen       <= 1'b0;
            issue_idx  <= '0;
          end
        end
        ST_SELF: self_rec <= rd_rec;
        ST_SCAN: begin
          if (match) begin
            issue_idx <= chk_idx + 1'b1;
            div_rem   <= tdiff[WIN_W-1:0];
            div_cnt   <= DCW'(F);
            t         <= (tdiff >= TIME_W'(win_eff)) ? FIX_ONE : '0;
          end else if (issue) begin
            issue_idx <= issue_idx + 1'b1;
            chk_idx   <= issue_idx;
            chk_valid <= 1'b1;
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_sh >= {1'b0, win_eff}) begin
            div_rem <= WIN_W'(div_sh - {1'b0, win_eff});
            t       <= {t[FW-2:0], 1'b1};
          end else begin
            div_rem <= div_sh[WIN_W-1:0];
            t       <= {t[FW-2:0], 1'b0};
          end
        end
        ST_SQUARE: t2 <= sq_full[F +: FW];
        ST_SCALE:  scaled <= sc_full[F +: FW];
        ST_ACC: begin
          total <= total + TW'(FIX_ONE - scaled);
          seen  <= 1'b1;
        end
        ST_FINISH: begin
          if (!need_root) begin
            result_valid   <= 1'b1;
            error_factor   <= big_total ? FACTOR_MAX : FACTOR_ONE;
            duplicate_seen <= seen;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            result_valid   <= 1'b1;
            error_factor   <= sqrt_root;
            duplicate_seen <= seen;
          end
        end
        default: ;
      endcase
    end
  end

  doei_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (rad_wide[RAD_W-1:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a preceding evaluation");

  a_plain_factor: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !duplicate_seen) |-> (error_factor == FACTOR_ONE))
    else $error("factor differs from one without a duplicate");

  a_check_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (state == ST_SCAN))
    else $error("scan read outstanding outside scan");

  a_root_only_in_root: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == ST_ROOT))
    else $error("square root finished outside its wait");

endmodule
